/* hw/rtl/qat_pkg.sv */
// Shared types, codes and defaults for the quoted argument tokenizer.
package qat_pkg;

   localparam int MAX_LINE_BYTES_DEF = 256;
   localparam int MAX_ARGS_DEF       = 8;
   localparam int QUEUE_DEPTH        = 4;

   localparam logic [7:0] CH_SPACE = 8'h20;
   localparam logic [7:0] CH_TAB   = 8'h09;
   localparam logic [7:0] CH_BSL   = 8'h5C;
   localparam logic [7:0] CH_DQ    = 8'h22;
   localparam logic [7:0] CH_SQ    = 8'h27;

   typedef enum logic [1:0] {
      KIND_BYTE = 2'd0,
      KIND_END  = 2'd1,
      KIND_DONE = 2'd2
   } kind_type;

   typedef enum logic [2:0] {
      ST_OK         = 3'd0,
      ST_TOO_MANY   = 3'd1,
      ST_BAD_ESCAPE = 3'd2,
      ST_TOO_LONG   = 3'd3,
      ST_UNTERM     = 3'd4
   } status_type;

   typedef enum logic [1:0] {
      QM_NONE   = 2'd0,
      QM_DOUBLE = 2'd1,
      QM_SINGLE = 2'd2
   } qmode_type;

   typedef struct packed {
      logic [7:0] ch;
      logic       line_end;
   } req_type;

   typedef struct packed {
      logic [1:0] kind;
      logic [7:0] out_byte;
      logic [2:0] token_index;
      logic [2:0] status;
      logic [3:0] token_count;
   } rsp_type;

   // classified character as it sits in the queue
   typedef struct packed {
      logic [7:0] ch;
      logic       line_end;
      logic       is_ws;
      logic       is_bsl;
      logic       is_dq;
      logic       is_sq;
   } cls_type;

endpackage

/* hw/rtl/quoted_argument_tokenizer.sv */
// Top level of the quoted argument tokenizer: front queue and back end.
//
//   channel  dir  handshake            beat
//   req_     in   req_valid/req_stall  qat_pkg::req_type (ch, line_end)
//   rsp_     out  rsp_valid/rsp_stall  qat_pkg::rsp_type (kind .. token_count)
//
// One request beat per cycle while req_stall is low; a beat reaches the back end
// through a four-entry queue; its response is registered in the cycle after the pop.
// Reset is synchronous and clears the queue, the line state and the response valid.
// req_stall rises only when the queue is full; rsp_stall holds the response register
// and, once a response is waiting, stops the back end taking further beats.
module quoted_argument_tokenizer #(
   parameter int MAX_LINE_BYTES = qat_pkg::MAX_LINE_BYTES_DEF,
   parameter int MAX_ARGS       = qat_pkg::MAX_ARGS_DEF
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  qat_pkg::req_type  req_data,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output qat_pkg::rsp_type  rsp_data
);

   logic             q_valid;
   logic             q_pop;
   qat_pkg::cls_type q_item;

   qat_front u_front (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .q_valid   (q_valid),
      .q_item    (q_item),
      .q_pop     (q_pop)
   );

   qat_back #(
      .MAX_LINE_BYTES (MAX_LINE_BYTES),
      .MAX_ARGS       (MAX_ARGS)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .q_valid   (q_valid),
      .q_item    (q_item),
      .q_pop     (q_pop),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

endmodule

/* hw/rtl/qat_front.sv */
// Front end: accepts request beats, classifies the character and queues it.
module qat_front (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  qat_pkg::req_type  req_data,
   output logic              q_valid,
   output qat_pkg::cls_type  q_item,
   input  logic              q_pop
);

   localparam int PW = $clog2(qat_pkg::QUEUE_DEPTH);
   localparam int CW = $clog2(qat_pkg::QUEUE_DEPTH + 1);

   qat_pkg::cls_type entry_ff [qat_pkg::QUEUE_DEPTH];
   logic [PW-1:0]    wr_ptr_ff, wr_ptr_in;
   logic [PW-1:0]    rd_ptr_ff, rd_ptr_in;
   logic [CW-1:0]    count_ff, count_in;
   qat_pkg::cls_type cls_in;
   logic             push;
   logic             pop;

   always_comb begin
      cls_in.ch       = req_data.ch;
      cls_in.line_end = req_data.line_end;
      cls_in.is_ws    = (req_data.ch == qat_pkg::CH_SPACE) || (req_data.ch == qat_pkg::CH_TAB);
      cls_in.is_bsl   = (req_data.ch == qat_pkg::CH_BSL);
      cls_in.is_dq    = (req_data.ch == qat_pkg::CH_DQ);
      cls_in.is_sq    = (req_data.ch == qat_pkg::CH_SQ);
   end

   assign req_stall = (count_ff == CW'(qat_pkg::QUEUE_DEPTH));
   assign push      = req_valid && !req_stall;
   assign q_valid   = (count_ff != '0);
   assign pop       = q_pop && q_valid;
   assign q_item    = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PW'(qat_pkg::QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PW'(qat_pkg::QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= cls_in;
      end
   end

endmodule

/* hw/rtl/qat_back.sv */
// Back end: tokenizer state update and registered response beat.
module qat_back #(
   parameter int MAX_LINE_BYTES = qat_pkg::MAX_LINE_BYTES_DEF,
   parameter int MAX_ARGS       = qat_pkg::MAX_ARGS_DEF
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              q_valid,
   input  qat_pkg::cls_type  q_item,
   output logic              q_pop,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output qat_pkg::rsp_type  rsp_data
);

   localparam int AW = $clog2(MAX_ARGS + 1);
   localparam int BW = $clog2(MAX_LINE_BYTES + 2);

   logic                in_token_ff, in_token_in;
   qat_pkg::qmode_type  quote_ff, quote_in;
   logic                esc_ff, esc_in;
   logic [AW-1:0]       argc_ff, argc_in;
   logic [BW-1:0]       bytes_ff, bytes_in;
   logic                err_ff, err_in;
   logic                rsp_valid_ff;
   qat_pkg::rsp_type    rsp_ff, rsp_in;
   logic                load;
   logic                pop;
   logic [4:0]          argc_ext;
   logic                to_byte;
   qat_pkg::qmode_type  qcode;

   assign pop       = q_valid && (!rsp_valid_ff || !rsp_stall);
   assign q_pop     = pop;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   always_comb begin
      in_token_in = in_token_ff;
      quote_in    = quote_ff;
      esc_in      = esc_ff;
      argc_in     = argc_ff;
      bytes_in    = bytes_ff;
      err_in      = err_ff;
      load        = 1'b0;
      to_byte     = 1'b0;
      rsp_in      = '0;
      argc_ext    = 5'(argc_ff);
      qcode       = q_item.is_dq ? qat_pkg::QM_DOUBLE : qat_pkg::QM_SINGLE;

      if (q_item.line_end) begin
         if (!err_ff) begin
            load               = 1'b1;
            rsp_in.kind        = qat_pkg::KIND_DONE;
            rsp_in.token_count = 4'(argc_ext);
            if (esc_ff) begin
               rsp_in.status = qat_pkg::ST_BAD_ESCAPE;
            end else if (quote_ff != qat_pkg::QM_NONE) begin
               rsp_in.status = qat_pkg::ST_UNTERM;
            end else begin
               rsp_in.status = qat_pkg::ST_OK;
            end
         end
         in_token_in = 1'b0;
         quote_in    = qat_pkg::QM_NONE;
         esc_in      = 1'b0;
         argc_in     = '0;
         bytes_in    = '0;
         err_in      = 1'b0;
      end else if (!err_ff && !(!in_token_ff && q_item.is_ws)) begin
         if (!in_token_ff && (argc_ff >= AW'(MAX_ARGS))) begin
            err_in             = 1'b1;
            load               = 1'b1;
            rsp_in.kind        = qat_pkg::KIND_DONE;
            rsp_in.status      = qat_pkg::ST_TOO_MANY;
            rsp_in.token_count = 4'(argc_ext);
         end else begin
            if (!in_token_ff) begin
               argc_in     = argc_ff + 1'b1;
               in_token_in = 1'b1;
               quote_in    = qat_pkg::QM_NONE;
               esc_in      = 1'b0;
            end
            argc_ext = 5'(argc_in);
            if (in_token_ff && esc_ff) begin
               esc_in = 1'b0;
               if (q_item.is_bsl || q_item.is_dq || q_item.is_sq || q_item.is_ws) begin
                  to_byte = 1'b1;
               end else begin
                  err_in             = 1'b1;
                  load               = 1'b1;
                  rsp_in.kind        = qat_pkg::KIND_DONE;
                  rsp_in.status      = qat_pkg::ST_BAD_ESCAPE;
                  rsp_in.token_count = 4'(argc_ext);
               end
            end else if (q_item.is_bsl) begin
               esc_in = 1'b1;
            end else if ((quote_in == qat_pkg::QM_NONE) && q_item.is_ws) begin
               in_token_in = 1'b0;
               if (bytes_ff <= BW'(MAX_LINE_BYTES)) begin
                  bytes_in = bytes_ff + 1'b1;
               end
               load               = 1'b1;
               rsp_in.kind        = qat_pkg::KIND_END;
               rsp_in.token_index = 3'(argc_ext - 5'd1);
               rsp_in.token_count = 4'(argc_ext);
            end else if (q_item.is_dq || q_item.is_sq) begin
               if (quote_in == qat_pkg::QM_NONE) begin
                  quote_in = qcode;
               end else if (quote_in == qcode) begin
                  quote_in = qat_pkg::QM_NONE;
               end else begin
                  to_byte = 1'b1;
               end
            end else begin
               to_byte = 1'b1;
            end

            if (to_byte) begin
               load               = 1'b1;
               rsp_in.token_count = 4'(argc_ext);
               if (bytes_ff >= BW'(MAX_LINE_BYTES)) begin
                  err_in        = 1'b1;
                  rsp_in.kind   = qat_pkg::KIND_DONE;
                  rsp_in.status = qat_pkg::ST_TOO_LONG;
               end else begin
                  bytes_in           = bytes_ff + 1'b1;
                  rsp_in.kind        = qat_pkg::KIND_BYTE;
                  rsp_in.out_byte    = q_item.ch;
                  rsp_in.token_index = 3'(argc_ext - 5'd1);
               end
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_token_ff  <= 1'b0;
         quote_ff     <= qat_pkg::QM_NONE;
         esc_ff       <= 1'b0;
         argc_ff      <= '0;
         bytes_ff     <= '0;
         err_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (pop) begin
            in_token_ff <= in_token_in;
            quote_ff    <= quote_in;
            esc_ff      <= esc_in;
            argc_ff     <= argc_in;
            bytes_ff    <= bytes_in;
            err_ff      <= err_in;
         end
         if (pop && load) begin
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (pop && load) begin
         rsp_ff <= rsp_in;
      end
   end

   a_line_end_clears: assert property (@(posedge clock) disable iff (reset)
      (pop && q_item.line_end) |=> (argc_ff == '0) && !in_token_ff && !err_ff && !esc_ff)
      else $error("state not cleared after line end");

   a_argc_bound: assert property (@(posedge clock) disable iff (reset)
      argc_ff <= AW'(MAX_ARGS))
      else $error("argument count above limit");

   a_bytes_bound: assert property (@(posedge clock) disable iff (reset)
      bytes_ff <= BW'(MAX_LINE_BYTES + 1))
      else $error("byte count above saturation");

   a_silent_after_error: assert property (@(posedge clock) disable iff (reset)
      (pop && err_ff && !q_item.line_end) |-> !load)
      else $error("result after latched error");

   a_escape_in_token: assert property (@(posedge clock) disable iff (reset)
      esc_ff |-> in_token_ff)
      else $error("escape pending outside an argument");

endmodule

/* tb/quoted_argument_tokenizer_tb.sv */
`timescale 1ns / 100ps
// Self-checking testbench for the quoted argument tokenizer: directed table, then random lines.
module quoted_argument_tokenizer_tb;

   localparam int LINE_LIMIT   = qat_pkg::MAX_LINE_BYTES_DEF;
   localparam int ARG_LIMIT    = qat_pkg::MAX_ARGS_DEF;
   localparam int BEAT_TARGET  = 1450;
   localparam int QUIET_LIMIT  = 1000;
   localparam int DRAIN_CYCLES = 16;

   typedef enum int {
      SHAPE_CLEAN,
      SHAPE_BROKEN,
      SHAPE_NOISE,
      SHAPE_CROWD,
      SHAPE_LONG
   } line_shape_type;

   typedef struct packed {
      qat_pkg::req_type beat;
      logic             fixed;
      qat_pkg::rsp_type want;
   } vec_row_type;

   localparam qat_pkg::rsp_type NO_RSP = '0;

   localparam vec_row_type DIRECTED [25] = '{
      '{'{8'h00, 1'b1}, 1'b1, '{qat_pkg::KIND_DONE, 8'h00, 3'd0, qat_pkg::ST_OK, 4'd0}},
      '{'{8'h61, 1'b0}, 1'b1, '{qat_pkg::KIND_BYTE, 8'h61, 3'd0, qat_pkg::ST_OK, 4'd1}},
      '{'{8'hFF, 1'b0}, 1'b1, '{qat_pkg::KIND_BYTE, 8'hFF, 3'd0, qat_pkg::ST_OK, 4'd1}},
      '{'{8'h00, 1'b0}, 1'b1, '{qat_pkg::KIND_BYTE, 8'h00, 3'd0, qat_pkg::ST_OK, 4'd1}},
      '{'{qat_pkg::CH_SPACE, 1'b0}, 1'b1,
        '{qat_pkg::KIND_END, 8'h00, 3'd0, qat_pkg::ST_OK, 4'd1}},
      '{'{qat_pkg::CH_TAB, 1'b0}, 1'b0, NO_RSP},
      '{'{qat_pkg::CH_DQ, 1'b0}, 1'b0, NO_RSP},
      '{'{qat_pkg::CH_SPACE, 1'b0}, 1'b0, NO_RSP},
      '{'{qat_pkg::CH_SQ, 1'b0}, 1'b0, NO_RSP},
      '{'{qat_pkg::CH_DQ, 1'b0}, 1'b0, NO_RSP},
      '{'{qat_pkg::CH_BSL, 1'b0}, 1'b0, NO_RSP},
      '{'{8'h71, 1'b0}, 1'b1,
        '{qat_pkg::KIND_DONE, 8'h00, 3'd0, qat_pkg::ST_BAD_ESCAPE, 4'd2}},
      '{'{8'h78, 1'b0}, 1'b0, NO_RSP},
      '{'{8'hA5, 1'b1}, 1'b0, NO_RSP},
      '{'{qat_pkg::CH_SQ, 1'b0}, 1'b0, NO_RSP},
      '{'{8'h62, 1'b0}, 1'b0, NO_RSP},
      '{'{8'h00, 1'b1}, 1'b1,
        '{qat_pkg::KIND_DONE, 8'h00, 3'd0, qat_pkg::ST_UNTERM, 4'd1}},
      '{'{qat_pkg::CH_BSL, 1'b0}, 1'b0, NO_RSP},
      '{'{8'hFF, 1'b1}, 1'b1,
        '{qat_pkg::KIND_DONE, 8'h00, 3'd0, qat_pkg::ST_BAD_ESCAPE, 4'd1}},
      '{'{qat_pkg::CH_BSL, 1'b0}, 1'b0, NO_RSP},
      '{'{qat_pkg::CH_SPACE, 1'b0}, 1'b0, NO_RSP},
      '{'{8'h00, 1'b1}, 1'b1, '{qat_pkg::KIND_DONE, 8'h00, 3'd0, qat_pkg::ST_OK, 4'd1}},
      '{'{qat_pkg::CH_DQ, 1'b0}, 1'b0, NO_RSP},
      '{'{qat_pkg::CH_BSL, 1'b0}, 1'b0, NO_RSP},
      '{'{8'h00, 1'b1}, 1'b1,
        '{qat_pkg::KIND_DONE, 8'h00, 3'd0, qat_pkg::ST_BAD_ESCAPE, 4'd1}}
   };

   logic             clock     = 1'b0;
   logic             reset     = 1'b1;
   logic             req_valid = 1'b0;
   logic             rsp_stall = 1'b0;
   qat_pkg::req_type req_data  = '0;
   logic             req_stall;
   logic             rsp_valid;
   qat_pkg::rsp_type rsp_data;

   // line state of the predictor
   logic               tok_open;
   qat_pkg::qmode_type quote_open;
   logic               esc_open;
   int unsigned        arg_seen;
   int unsigned        buf_used;
   logic               line_failed;

   qat_pkg::rsp_type pending_tokens [$];
   qat_pkg::req_type line_q [$];
   bit               calm = 1'b0;

   int fail_count      = 0;
   int beats_sent      = 0;
   int results_checked = 0;
   int lines_sent      = 0;
   int quiet_cycles    = 0;
   int outcome_count [5];

   quoted_argument_tokenizer #(
      .MAX_LINE_BYTES(LINE_LIMIT),
      .MAX_ARGS      (ARG_LIMIT)
   ) dut (.*);

   always #2 clock = ~clock;

   function automatic void clear_line();
      tok_open    = 1'b0;
      quote_open  = qat_pkg::QM_NONE;
      esc_open    = 1'b0;
      arg_seen    = 0;
      buf_used    = 0;
      line_failed = 1'b0;
   endfunction

   function automatic qat_pkg::rsp_type make_rsp(input logic [1:0] kind, input logic [7:0] b,
                                                 input int unsigned idx, input logic [2:0] st);
      qat_pkg::rsp_type r;
      r.kind        = kind;
      r.out_byte    = b;
      r.token_index = idx[2:0];
      r.status      = st;
      r.token_count = arg_seen[3:0];
      return r;
   endfunction

   function automatic qat_pkg::rsp_type line_error(input logic [2:0] st);
      line_failed = 1'b1;
      return make_rsp(qat_pkg::KIND_DONE, 8'h00, 0, st);
   endfunction

   // one character or line end in, at most one token beat out
   function automatic bit split_char(input qat_pkg::req_type beat, output qat_pkg::rsp_type res);
      logic               ws;
      qat_pkg::qmode_type q;
      ws  = (beat.ch == qat_pkg::CH_SPACE) || (beat.ch == qat_pkg::CH_TAB);
      res = NO_RSP;
      if (beat.line_end) begin
         if (line_failed) begin
            clear_line();
            return 1'b0;
         end
         res = make_rsp(qat_pkg::KIND_DONE, 8'h00, 0,
                        esc_open ? qat_pkg::ST_BAD_ESCAPE :
                        (quote_open != qat_pkg::QM_NONE ? qat_pkg::ST_UNTERM : qat_pkg::ST_OK));
         clear_line();
         return 1'b1;
      end
      if (line_failed)
         return 1'b0;
      if (!tok_open) begin
         if (ws)
            return 1'b0;
         if (arg_seen >= ARG_LIMIT) begin
            res = line_error(qat_pkg::ST_TOO_MANY);
            return 1'b1;
         end
         arg_seen++;
         tok_open   = 1'b1;
         quote_open = qat_pkg::QM_NONE;
         esc_open   = 1'b0;
      end
      if (esc_open) begin
         esc_open = 1'b0;
         if (beat.ch != qat_pkg::CH_BSL && beat.ch != qat_pkg::CH_DQ &&
             beat.ch != qat_pkg::CH_SQ && !ws) begin
            res = line_error(qat_pkg::ST_BAD_ESCAPE);
            return 1'b1;
         end
      end else if (beat.ch == qat_pkg::CH_BSL) begin
         esc_open = 1'b1;
         return 1'b0;
      end else if (quote_open == qat_pkg::QM_NONE && ws) begin
         tok_open = 1'b0;
         if (buf_used <= LINE_LIMIT)
            buf_used++;
         res = make_rsp(qat_pkg::KIND_END, 8'h00, arg_seen - 1, qat_pkg::ST_OK);
         return 1'b1;
      end else if (beat.ch == qat_pkg::CH_DQ || beat.ch == qat_pkg::CH_SQ) begin
         if (beat.ch == qat_pkg::CH_DQ)
            q = qat_pkg::QM_DOUBLE;
         else
            q = qat_pkg::QM_SINGLE;
         if (quote_open == qat_pkg::QM_NONE) begin
            quote_open = q;
            return 1'b0;
         end
         if (quote_open == q) begin
            quote_open = qat_pkg::QM_NONE;
            return 1'b0;
         end
      end
      if (buf_used >= LINE_LIMIT) begin
         res = line_error(qat_pkg::ST_TOO_LONG);
         return 1'b1;
      end
      buf_used++;
      res = make_rsp(qat_pkg::KIND_BYTE, beat.ch, arg_seen - 1, qat_pkg::ST_OK);
      return 1'b1;
   endfunction

   function automatic logic [7:0] plain_char();
      logic [7:0] c;
      do
         c = 8'($urandom_range(0, 255));
      while (c == qat_pkg::CH_SPACE || c == qat_pkg::CH_TAB || c == qat_pkg::CH_BSL ||
             c == qat_pkg::CH_DQ || c == qat_pkg::CH_SQ);
      return c;
   endfunction

   function automatic logic [7:0] pick_escapable();
      case ($urandom_range(0, 4))
         0: return qat_pkg::CH_BSL;
         1: return qat_pkg::CH_DQ;
         2: return qat_pkg::CH_SQ;
         3: return qat_pkg::CH_SPACE;
         default: return qat_pkg::CH_TAB;
      endcase
   endfunction

   function automatic logic [7:0] noise_char();
      return $urandom_range(0, 1) ? pick_escapable() : 8'($urandom_range(0, 255));
   endfunction

   function automatic void put(input logic [7:0] c, input logic e);
      qat_pkg::req_type b;
      b.ch       = c;
      b.line_end = e;
      line_q.push_back(b);
   endfunction

   function automatic void put_gap();
      repeat ($urandom_range(1, 2))
         put($urandom_range(0, 1) ? qat_pkg::CH_SPACE : qat_pkg::CH_TAB, 1'b0);
   endfunction

   function automatic void put_arg(input int unsigned pieces);
      logic [7:0] qc;
      repeat (pieces) begin
         case ($urandom_range(0, 5))
            0, 1, 2: put(plain_char(), 1'b0);
            3: begin
               put(qat_pkg::CH_BSL, 1'b0);
               put(pick_escapable(), 1'b0);
            end
            default: begin
               qc = $urandom_range(0, 1) ? qat_pkg::CH_DQ : qat_pkg::CH_SQ;
               put(qc, 1'b0);
               repeat ($urandom_range(0, 4)) begin
                  case ($urandom_range(0, 3))
                     0: put($urandom_range(0, 1) ? qat_pkg::CH_SPACE : qat_pkg::CH_TAB, 1'b0);
                     1: put(qc == qat_pkg::CH_DQ ? qat_pkg::CH_SQ : qat_pkg::CH_DQ, 1'b0);
                     2: begin
                        put(qat_pkg::CH_BSL, 1'b0);
                        put(pick_escapable(), 1'b0);
                     end
                     default: put(plain_char(), 1'b0);
                  endcase
               end
               put(qc, 1'b0);
            end
         endcase
      end
   endfunction

   function automatic void build_line(input line_shape_type shape);
      int n;
      line_q.delete();
      case (shape)
         SHAPE_CROWD: begin
            n = $urandom_range(ARG_LIMIT + 1, ARG_LIMIT + 2);
            for (int i = 0; i < n; i++) begin
               if (i != 0)
                  put_gap();
               put_arg($urandom_range(1, 2));
            end
         end
         SHAPE_LONG: begin
            n = $urandom_range(1, 3);
            for (int i = 0; i < n; i++) begin
               if (i != 0)
                  put_gap();
               repeat ((LINE_LIMIT + 24) / n)
                  put(plain_char(), 1'b0);
            end
         end
         SHAPE_NOISE: begin
            repeat ($urandom_range(0, 20))
               put(noise_char(), 1'b0);
         end
         default: begin
            if ($urandom_range(0, 3) == 0)
               put_gap();
            n = (shape == SHAPE_BROKEN) ? $urandom_range(0, 3) : $urandom_range(0, ARG_LIMIT + 1);
            for (int i = 0; i < n; i++) begin
               if (i != 0)
                  put_gap();
               put_arg($urandom_range(1, 4));
            end
            if (shape == SHAPE_BROKEN) begin
               case ($urandom_range(0, 2))
                  0: begin
                     put(qat_pkg::CH_BSL, 1'b0);
                     put(plain_char(), 1'b0);
                  end
                  1: begin
                     put($urandom_range(0, 1) ? qat_pkg::CH_DQ : qat_pkg::CH_SQ, 1'b0);
                     repeat ($urandom_range(0, 3))
                        put(plain_char(), 1'b0);
                  end
                  default: put(qat_pkg::CH_BSL, 1'b0);
               endcase
            end else if ($urandom_range(0, 3) == 0) begin
               put_gap();
            end
         end
      endcase
      put(8'($urandom_range(0, 255)), 1'b1);
   endfunction

   task automatic send_beat(input qat_pkg::req_type beat, output bit hit,
                            output qat_pkg::rsp_type res);
      int gap;
      gap = calm ? 0 : $urandom_range(0, 3);
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= beat;
      do @(posedge clock); while (req_stall);
      beats_sent++;
      hit = split_char(beat, res);
   endtask

   task automatic await_drain();
      req_valid <= 1'b0;
      do @(posedge clock); while (pending_tokens.size() != 0);
   endtask

   task automatic compare_field(input string name, input logic [7:0] want_v,
                                input logic [7:0] got_v);
      if (got_v !== want_v) begin
         $error("%s: expected %0h, got %0h", name, want_v, got_v);
         fail_count++;
      end
   endtask

   // stimulus
   initial begin
      bit               hit;
      qat_pkg::rsp_type res;
      line_shape_type   shape;
      int               r;
      clear_line();
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      foreach (DIRECTED[i]) begin
         send_beat(DIRECTED[i].beat, hit, res);
         if (DIRECTED[i].fixed)
            pending_tokens.push_back(DIRECTED[i].want);
         else if (hit)
            pending_tokens.push_back(res);
      end
      await_drain();
      while (beats_sent < BEAT_TARGET) begin
         r = $urandom_range(0, 99);
         if (lines_sent == 0)
            shape = SHAPE_CROWD;
         else if (lines_sent == 1 || r == 0)
            shape = SHAPE_LONG;
         else if (r < 8)
            shape = SHAPE_CROWD;
         else if (r < 70)
            shape = SHAPE_CLEAN;
         else if (r < 85)
            shape = SHAPE_BROKEN;
         else
            shape = SHAPE_NOISE;
         build_line(shape);
         calm = ($urandom_range(0, 3) == 0);
         foreach (line_q[i]) begin
            send_beat(line_q[i], hit, res);
            if (hit)
               pending_tokens.push_back(res);
         end
         lines_sent++;
         if (lines_sent % 25 == 0)
            await_drain();
      end
      await_drain();
      repeat (DRAIN_CYCLES) @(posedge clock);
      $display("%0d request beats over %0d lines, %0d result beats checked",
               beats_sent, lines_sent, results_checked);
      $display("line outcomes: ok %0d, too many %0d, bad escape %0d, too long %0d, open quote %0d",
               outcome_count[qat_pkg::ST_OK], outcome_count[qat_pkg::ST_TOO_MANY],
               outcome_count[qat_pkg::ST_BAD_ESCAPE], outcome_count[qat_pkg::ST_TOO_LONG],
               outcome_count[qat_pkg::ST_UNTERM]);
      if (fail_count == 0 && pending_tokens.size() == 0) begin
         $display("quoted_argument_tokenizer regression: pass");
      end else begin
         $display("quoted_argument_tokenizer regression: fail");
      end
      $finish;
   end

   // result side back-pressure
   initial begin
      int n;
      while (reset) @(posedge clock);
      forever begin
         n = calm ? 0 : $urandom_range(0, 3);
         if (n != 0) begin
            rsp_stall <= 1'b1;
            repeat (n) @(posedge clock);
         end
         rsp_stall <= 1'b0;
         do @(posedge clock); while (!rsp_valid);
      end
   end

   always @(posedge clock) begin
      qat_pkg::rsp_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_tokens.size() == 0) begin
            $error("result beat with nothing expected: %p", rsp_data);
            fail_count++;
         end else begin
            want = pending_tokens.pop_front();
            compare_field("kind", 8'(want.kind), 8'(rsp_data.kind));
            compare_field("out_byte", want.out_byte, rsp_data.out_byte);
            compare_field("token_index", 8'(want.token_index), 8'(rsp_data.token_index));
            compare_field("status", 8'(want.status), 8'(rsp_data.status));
            compare_field("token_count", 8'(want.token_count), 8'(rsp_data.token_count));
            if (want.kind == qat_pkg::KIND_DONE && want.status <= qat_pkg::ST_UNTERM)
               outcome_count[want.status]++;
            results_checked++;
         end
      end
   end

   // watchdog: no beat moving on either side for too long
   always @(posedge clock) begin
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall))
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= QUIET_LIMIT) begin
         $display("quoted_argument_tokenizer regression: fail");
         $finish;
      end
   end

endmodule
